### sv/qat_pkg.sv
// qat_pkg: shared types, character codes and helpers for the quoted argument tokenizer
// used by qat_step and quoted_argument_tokenizer; depends on nothing else
`default_nettype none

package qat_pkg;

    // line length bound and the saturating position limit derived from it
    localparam int MAX_LINE_BYTES = 65536;
    localparam int POS_W          = 16;
    localparam int POS_MAX_INT    = (MAX_LINE_BYTES - 1 > 65535) ? 65535 : MAX_LINE_BYTES - 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_MAX_INT[POS_W-1:0];

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;

    // tokenizer state carried from word to word
    typedef struct packed {
        logic             dbl_open;
        logic             sgl_open;
        logic             esc_pending;
        logic             tok_nonempty;
        logic             begin_known;
        logic [POS_W-1:0] begin_pos;
        logic [POS_W-1:0] line_pos;
    } state_t;

    // one result word
    typedef struct packed {
        logic             char_valid;
        logic [7:0]       char_out;
        logic             token_end;
        logic [POS_W-1:0] token_offset;
        logic             line_done;
        logic             line_ok;
    } result_t;

    // whitespace test
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) ||
               (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

`default_nettype wire

### sv/quoted_argument_tokenizer.sv
// quoted_argument_tokenizer: top level, input register, tokenizer state and result register
// depends on qat_pkg and qat_step
//
// Usage: a command line enters one byte per word on the input channel
// (in_valid / in_ready, byte_in, last_of_line set on the final byte).
// Every input word gives exactly one result word on the output channel
// (out_valid / out_ready): the literal character if it belongs to an argument,
// token_end with token_offset when an argument is complete, and line_done with
// line_ok on the last byte of a line.
// A word accepted on the input passes the input register, then the result register,
// before it is presented on the output. Throughput: one word per cycle while the
// receiver does not stall; the per-byte decision is a few flag bits and one 16-bit
// position increment between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; in_ready drops once both are full.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// quote, escape and position state to the start of a line; the same state is
// restored after each last byte of a line.
`default_nettype none

module quoted_argument_tokenizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_of_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             char_valid,
    output logic [7:0]       char_out,
    output logic             token_end,
    output logic [15:0]      token_offset,
    output logic             line_done,
    output logic             line_ok
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic             advance;
    qat_pkg::state_t  state_reg;
    qat_pkg::state_t  state_next;
    qat_pkg::result_t result_reg;
    qat_pkg::result_t result_next;

    // handshake: move a word forward when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // per-byte decision
    qat_step u_step (
        .byte_val  (byte_reg),
        .last      (last_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
            last_reg <= last_of_line;
        end
    end

    // tokenizer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign char_valid   = result_reg.char_valid;
    assign char_out     = result_reg.char_out;
    assign token_end    = result_reg.token_end;
    assign token_offset = result_reg.token_offset;
    assign line_done    = result_reg.line_done;
    assign line_ok      = result_reg.line_ok;

endmodule

`default_nettype wire

### sv/qat_step.sv
// qat_step: combinational per-byte decision of the tokenizer
// takes the current state and one byte, gives the next state and the result word; uses qat_pkg
`default_nettype none

module qat_step (
    input  wire logic [7:0]      byte_val,
    input  wire logic            last,
    input  wire qat_pkg::state_t state_cur,
    output qat_pkg::state_t      state_nxt,
    output qat_pkg::result_t     result
);

    logic                      blank;
    logic                      cval;
    logic                      tend;
    logic                      err;
    logic                      lok;
    logic [qat_pkg::POS_W-1:0] toff;
    qat_pkg::state_t           ns;

    assign blank = qat_pkg::is_blank(byte_val);

    // byte classification and quote / escape tracking
    always_comb
    begin
        ns   = state_cur;
        cval = 1'b0;
        tend = 1'b0;
        err  = 1'b0;
        lok  = 1'b0;
        toff = '0;

        if (state_cur.esc_pending)
        begin
            ns.esc_pending = 1'b0;
            cval           = 1'b1;
        end
        else
        begin
            // first non-blank byte since the last emitted token marks its start
            if (!state_cur.begin_known && !blank)
            begin
                ns.begin_known = 1'b1;
                ns.begin_pos   = state_cur.line_pos;
            end

            if (blank)
            begin
                if (state_cur.sgl_open || state_cur.dbl_open)
                begin
                    cval = 1'b1;
                end
                else if (state_cur.tok_nonempty)
                begin
                    tend            = 1'b1;
                    toff            = state_cur.begin_pos;
                    ns.tok_nonempty = 1'b0;
                    ns.begin_known  = 1'b0;
                end
            end
            else if (byte_val == qat_pkg::CH_BACKSLASH)
            begin
                if (last)
                    err = 1'b1;
                else
                    ns.esc_pending = 1'b1;
            end
            else if (byte_val == qat_pkg::CH_DQUOTE)
            begin
                if (state_cur.sgl_open)
                    cval = 1'b1;
                else
                    ns.dbl_open = !state_cur.dbl_open;
            end
            else if (byte_val == qat_pkg::CH_SQUOTE)
            begin
                if (state_cur.dbl_open)
                    cval = 1'b1;
                else
                    ns.sgl_open = !state_cur.sgl_open;
            end
            else
            begin
                cval = 1'b1;
            end
        end

        if (cval)
            ns.tok_nonempty = 1'b1;

        // end of line closes the pending token unless a backslash dangles; returns to reset state
        if (last)
        begin
            if (!err)
            begin
                if (ns.tok_nonempty)
                begin
                    tend = 1'b1;
                    toff = ns.begin_pos;
                end
                lok = !ns.dbl_open && !ns.sgl_open;
            end
            ns = '0;
        end
        else if (state_cur.line_pos < qat_pkg::POS_LIMIT)
        begin
            ns.line_pos = state_cur.line_pos + 1'b1;
        end

        state_nxt = ns;
    end

    // result word with unused fields zeroed
    always_comb
    begin
        result.char_valid   = cval;
        result.char_out     = cval ? byte_val : 8'h00;
        result.token_end    = tend;
        result.token_offset = tend ? toff : '0;
        result.line_done    = last;
        result.line_ok      = last && lok;
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// testbench for quoted_argument_tokenizer: byte stream stimulus, a token predictor and
// an in-order check of every result word
// depends on qat_pkg and the quoted_argument_tokenizer rtl

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import qat_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 1200;
    localparam int QUIET_WORDS   = 300;
    localparam int DRAIN_CYCLES  = 10;

    // predicts the result word of every accepted byte and checks results in order
    class token_predictor;
        logic             in_dquote;
        logic             in_squote;
        logic             escaped;
        logic             has_chars;
        logic             start_seen;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] cur_pos;
        result_t          expected_words[$];
        int               errors;
        int               lines_seen;
        int               tokens_seen;
        int               words_checked;

        function new();
            errors        = 0;
            lines_seen    = 0;
            tokens_seen   = 0;
            words_checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            in_dquote  = 1'b0;
            in_squote  = 1'b0;
            escaped    = 1'b0;
            has_chars  = 1'b0;
            start_seen = 1'b0;
            start_pos  = '0;
            cur_pos    = '0;
        endfunction

        function bit is_white(input logic [7:0] c);
            return c == CH_SPACE || c == CH_LF || c == CH_CR ||
                   c == CH_TAB || c == CH_VT || c == CH_FF;
        endfunction

        // note one accepted byte and queue the word it must produce
        function void take_byte(input logic [7:0] c, input logic last);
            result_t r;
            bit      keep;
            bit      dangling;
            r        = '0;
            keep     = 1'b0;
            dangling = 1'b0;
            if (escaped)
            begin
                escaped = 1'b0;
                keep    = 1'b1;
            end
            else
            begin
                // first non-blank byte since the last argument marks its start
                if (!start_seen && !is_white(c))
                begin
                    start_seen = 1'b1;
                    start_pos  = cur_pos;
                end
                if (is_white(c))
                begin
                    if (in_squote || in_dquote)
                        keep = 1'b1;
                    else if (has_chars)
                    begin
                        r.token_end    = 1'b1;
                        r.token_offset = start_pos;
                        has_chars      = 1'b0;
                        start_seen     = 1'b0;
                    end
                end
                else if (c == CH_BACKSLASH)
                begin
                    if (last)
                        dangling = 1'b1;
                    else
                        escaped = 1'b1;
                end
                else if (c == CH_DQUOTE)
                begin
                    if (in_squote)
                        keep = 1'b1;
                    else
                        in_dquote = !in_dquote;
                end
                else if (c == CH_SQUOTE)
                begin
                    if (in_dquote)
                        keep = 1'b1;
                    else
                        in_squote = !in_squote;
                end
                else
                    keep = 1'b1;
            end

            if (keep)
            begin
                has_chars    = 1'b1;
                r.char_valid = 1'b1;
                r.char_out   = c;
            end

            // end of line closes the pending argument unless a backslash dangles
            if (last)
            begin
                r.line_done = 1'b1;
                if (!dangling)
                begin
                    if (has_chars)
                    begin
                        r.token_end    = 1'b1;
                        r.token_offset = start_pos;
                    end
                    r.line_ok = !in_dquote && !in_squote;
                end
                clear_line();
                lines_seen++;
            end
            else if (cur_pos < POS_LIMIT)
                cur_pos = cur_pos + 1'b1;

            if (r.token_end)
                tokens_seen++;
            expected_words = {expected_words, r};
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(input result_t got);
            result_t want;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing predicted");
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.char_valid !== want.char_valid)
            begin
                $error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
                errors++;
            end
            if (got.char_out !== want.char_out)
            begin
                $error("char_out: expected %02h, got %02h", want.char_out, got.char_out);
                errors++;
            end
            if (got.token_end !== want.token_end)
            begin
                $error("token_end: expected %0d, got %0d", want.token_end, got.token_end);
                errors++;
            end
            if (got.token_offset !== want.token_offset)
            begin
                $error("token_offset: expected %0d, got %0d",
                       want.token_offset, got.token_offset);
                errors++;
            end
            if (got.line_done !== want.line_done)
            begin
                $error("line_done: expected %0d, got %0d", want.line_done, got.line_done);
                errors++;
            end
            if (got.line_ok !== want.line_ok)
            begin
                $error("line_ok: expected %0d, got %0d", want.line_ok, got.line_ok);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in      = 8'h00;
    logic        last_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        token_end;
    logic [15:0] token_offset;
    logic        line_done;
    logic        line_ok;

    token_predictor predictor = new();
    logic [7:0]     line_q[$];
    int             words_sent    = 0;
    int             cycle_count   = 0;
    bit             quiet         = 1'b0;
    bit             hold_request  = 1'b0;

    quoted_argument_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .last_of_line (last_of_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_valid   (char_valid),
        .char_out     (char_out),
        .token_end    (token_end),
        .token_offset (token_offset),
        .line_done    (line_done),
        .line_ok      (line_ok)
    );

    // clock
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, predictor.pending());
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: checks accepted words, stalls in bursts and once for a long hold
    initial
    begin
        result_t got;
        int      hold_left;
        int      stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.char_valid   = char_valid;
                got.char_out     = char_out;
                got.token_end    = token_end;
                got.token_offset = token_offset;
                got.line_done    = line_done;
                got.line_ok      = line_ok;
                predictor.check_word(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_ready   <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one byte and wait for its handshake, then maybe idle
    task automatic send_word(input logic [7:0] c, input logic last);
        in_valid     <= 1'b1;
        byte_in      <= c;
        last_of_line <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predictor.take_byte(c, last);
        words_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_q.size(); i++)
            send_word(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    // sender pause until every predicted word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predictor.pending() != 0)
            @(posedge clk);
    endtask

    // append one byte to the line being built
    function automatic void queue_byte(input logic [7:0] c);
        line_q = {line_q, c};
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte(8'(s[i]));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_LF;
            2:       return CH_CR;
            3:       return CH_TAB;
            4:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // byte with no special meaning: printable or high half
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            c = 8'($urandom_range(128, 255));
        else
            c = 8'($urandom_range(33, 126));
        if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BACKSLASH)
            c = 8'h5F;
        return c;
    endfunction

    // any byte, weighted toward the ones the tokenizer reacts to
    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(97, 122));
            3, 4:    return blank_char();
            5:       return CH_DQUOTE;
            6:       return CH_SQUOTE;
            7:       return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random lines: mostly well-formed argument lists, the rest raw noise
    task automatic run_random(input int count);
        int         first;
        int         a;
        int         p;
        int         n;
        logic [7:0] c;
        first = words_sent;
        while (words_sent - first < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    queue_byte(blank_char());
                for (a = $urandom_range(1, 4); a > 0; a--)
                begin
                    for (p = $urandom_range(1, 3); p > 0; p--)
                    begin
                        case ($urandom_range(0, 3))
                            0:
                            begin
                                repeat ($urandom_range(1, 4)) queue_byte(plain_char());
                            end
                            1:
                            begin
                                // single quoted piece, blanks allowed inside
                                queue_byte(CH_SQUOTE);
                                for (n = $urandom_range(0, 4); n > 0; n--)
                                begin
                                    c = any_char();
                                    if (c == CH_SQUOTE || c == CH_BACKSLASH)
                                        c = blank_char();
                                    queue_byte(c);
                                end
                                queue_byte(CH_SQUOTE);
                            end
                            2:
                            begin
                                // double quoted piece with escaped quotes and backslashes
                                queue_byte(CH_DQUOTE);
                                for (n = $urandom_range(0, 4); n > 0; n--)
                                begin
                                    c = any_char();
                                    if (c == CH_DQUOTE || c == CH_BACKSLASH)
                                        queue_byte(CH_BACKSLASH);
                                    queue_byte(c);
                                end
                                queue_byte(CH_DQUOTE);
                            end
                            default:
                            begin
                                queue_byte(CH_BACKSLASH);
                                queue_byte(8'($urandom_range(0, 255)));
                            end
                        endcase
                    end
                    if (a > 1)
                        repeat ($urandom_range(1, 3)) queue_byte(blank_char());
                end
                if ($urandom_range(0, 3) == 0)
                    queue_byte(blank_char());
            end
            else
            begin
                repeat ($urandom_range(1, 16)) queue_byte(any_char());
            end
            send_line();
        end
    endtask

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: one-byte line, byte extremes, lone backslash
        add_text("a");
        send_line();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        send_line();
        queue_byte(CH_BACKSLASH);
        send_line();

        // every whitespace code, line ending on a blank
        queue_byte(CH_TAB);
        add_text("a");
        queue_byte(CH_LF);
        queue_byte(CH_CR);
        add_text("b");
        queue_byte(CH_VT);
        queue_byte(CH_FF);
        queue_byte(CH_SPACE);
        send_line();

        // empty quoted pair keeps its start position
        add_text(" '' x");
        send_line();
        // single quote literal inside double quotes, quote left open at line end
        add_text("\"'a b");
        send_line();
        // double quote literal inside single quotes, escaped last byte
        add_text("'\"'\\q");
        send_line();
        // backslash at line end drops the pending argument
        add_text("a\\");
        send_line();

        wait_drained();

        // random lines with one long receiver hold while bytes keep coming
        hold_request = 1'b1;
        run_random(RANDOM_WORDS);
        wait_drained();

        // final stretch with no idling on either side
        quiet = 1'b1;
        run_random(QUIET_WORDS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d lines, %0d arguments, %0d result words in %0d cycles",
                 predictor.lines_seen, predictor.tokens_seen,
                 predictor.words_checked, cycle_count);
        $display("summary: quotes, escapes, all blanks, open quotes, stalls and a long hold");
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
